### sv/present80_block_encrypt_assert.svh
// Assertion macros for the PRESENT-80 encryption pipeline
`ifndef PRESENT80_BLOCK_ENCRYPT_ASSERT_SVH
`define PRESENT80_BLOCK_ENCRYPT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define P80_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// antecedent implies consequent in the next cycle
`define P80_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### sv/p80_pkg.sv
// Types, constants and round functions for the PRESENT-80 encryption pipeline
`timescale 1ns / 1ps
package p80_pkg;

	localparam int unsigned BLOCK_W        = 64;
	localparam int unsigned KEY_W          = 80;
	localparam int unsigned KEY_HIGH_W     = 16;
	localparam int unsigned RND_W          = 5;
	localparam int unsigned ROUND_COUNT_DEF = 31;
	localparam int unsigned CFG_INDEX_W    = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

	// one pipeline beat: cipher state plus the round key that goes with it
	typedef struct packed {
		logic               valid;
		logic [BLOCK_W-1:0] state;
		logic [KEY_W-1:0]   key;
	} stage_t;

	function automatic logic [3:0] sbox(input logic [3:0] x);
		logic [3:0] y;
		unique case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			default: y = 4'h2;
		endcase
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] nibble_subst(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			r[4*n +: 4] = sbox(s[4*n +: 4]);
		end
		return r;
	endfunction

	// bit i goes to 16*i mod 63: a 6-bit rotate left by four, bit 63 fixed
	function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		logic [5:0]         src;
		r = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			src = 6'(i);
			r[{src[1:0], src[5:2]}] = s[i];
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
			input logic [RND_W-1:0] rnd);
		logic [KEY_W-1:0] n;
		n = {k[18:0], k[KEY_W-1:19]};
		n[79:76] = sbox(n[79:76]);
		n[19:15] = n[19:15] ^ rnd;
		return n;
	endfunction

endpackage

### sv/p80_round.sv
// One PRESENT round as a pipeline stage: add key, S-box layer, permutation, key schedule
`timescale 1ns / 1ps
module p80_round import p80_pkg::*; #(
	parameter logic [RND_W-1:0] ROUND_IDX = 5'd1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  stage_t din,
	output stage_t dout
);

	logic               valid_s1;
	logic [BLOCK_W-1:0] state_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [BLOCK_W-1:0] mixed;

	assign mixed = din.state ^ din.key[KEY_W-1:KEY_W-BLOCK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s1 <= perm_layer(nibble_subst(mixed));
			key_s1   <= key_update(din.key, ROUND_IDX);
		end
	end

	assign dout.valid = valid_s1;
	assign dout.state = state_s1;
	assign dout.key   = key_s1;

endmodule

### sv/p80_out_buf.sv
// Final whitening, output register and skid slot of the PRESENT-80 pipeline
`timescale 1ns / 1ps
`include "present80_block_encrypt_assert.svh"
module p80_out_buf import p80_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stage_t             last,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [BLOCK_W-1:0] ciphertext,
	output logic               adv
);

	logic               out_valid_q;
	logic [BLOCK_W-1:0] cipher_q;
	logic               skid_valid_q;
	logic [BLOCK_W-1:0] skid_q;
	logic [BLOCK_W-1:0] whitened;
	logic               arrive;

	// pipeline only moves while the skid slot is free
	assign adv      = !skid_valid_q;
	assign arrive   = adv && last.valid;
	assign whitened = last.state ^ last.key[KEY_W-1:KEY_W-BLOCK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arrive;
			end
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				cipher_q <= skid_q;
			end else if (arrive) begin
				cipher_q <= whitened;
			end
		end else if (arrive) begin
			skid_q <= whitened;
		end
	end

	assign out_valid  = out_valid_q;
	assign ciphertext = cipher_q;

	`P80_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid holds a beat while output is empty")
	`P80_ASSERT_NEXT(a_stalled_arrival_kept, clk, arst_n, out_valid_q && !out_ready && arrive, skid_valid_q, "beat arriving at a stalled output was dropped")
	`P80_ASSERT_NEXT(a_skid_holds, clk, arst_n, skid_valid_q && !out_ready, skid_valid_q && out_valid_q, "skid beat lost while output stalled")
	`P80_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && out_ready, out_valid_q && !skid_valid_q, "skid beat not moved to output")

endmodule

### sv/present80_block_encrypt.sv
// Top level of the PRESENT-80 block encryption pipeline
// PRESENT-80 encryption, one 64-bit block per clock. Each of the ROUND_COUNT rounds is its own
// register stage carrying the block and its running key schedule, followed by the whitening
// XOR into an output register with a one-beat skid slot. Throughput is one beat per cycle while
// out_ready is high. A stall at the output freezes the round stages once the skid slot fills;
// in_ready then drops for as long as it stays full. The 80-bit key is written through the cfg
// channel (index 0: key bits 63..0, index 1: key bits 79..64, other indexes ignored) and is
// sampled as each block enters, so it must only be changed while no block is in flight.
`timescale 1ns / 1ps
module present80_block_encrypt import p80_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [BLOCK_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [BLOCK_W-1:0]     plaintext,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [BLOCK_W-1:0]     ciphertext
);

	logic [BLOCK_W-1:0]    key_low_q;
	logic [KEY_HIGH_W-1:0] key_high_q;
	logic                  adv;
	stage_t                pipe [0:ROUND_COUNT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end else if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data[KEY_HIGH_W-1:0];
			end
		end
	end

	assign in_ready       = adv;
	assign pipe[0].valid  = in_valid;
	assign pipe[0].state  = plaintext;
	assign pipe[0].key    = {key_high_q, key_low_q};

	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
		p80_round #(
			.ROUND_IDX(RND_W'(g + 1))
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (pipe[g]),
			.dout   (pipe[g+1])
		);
	end

	p80_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.last       (pipe[ROUND_COUNT]),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.ciphertext (ciphertext),
		.adv        (adv)
	);

endmodule
